@@ hdl/hem3_pkg.sv @@
package hem3_pkg;

    // Fraction bits of the quotient, and quotient bits below the saturation point
    localparam int QFB    = 6;
    localparam int QB     = QFB + 7;
    localparam int NUM_W  = 17;
    localparam int DEN_W  = 26;
    localparam int REM_W  = DEN_W + 1;
    localparam int NUM_SH = 16 + QFB - QB;
    localparam int IDX_W  = 8;

    // Divider and search steps, packed two to a stage
    localparam int STEPS  = 2;
    localparam int MSTEPS = QB + IDX_W;
    localparam int NSTG   = (MSTEPS + STEPS - 1) / STEPS;

    // Register indexes
    localparam logic [1:0] REG_GRAY   = 2'd0;
    localparam logic [1:0] REG_GAIN_M = 2'd1;
    localparam logic [1:0] REG_GAIN_U = 2'd2;
    localparam logic [1:0] REG_GAIN_O = 2'd3;

    localparam logic [63:0] ONE_Q30   = 64'd1 << 30;
    localparam logic [63:0] FRAC_MASK = ONE_Q30 - 64'd1;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;

    typedef struct packed {
        logic [7:0] median_pixel;
        logic [7:0] under_pixel;
        logic [7:0] over_pixel;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] merged_pixel;
        logic [6:0] weighted_median;
        logic [6:0] weighted_under;
        logic [6:0] weighted_over;
    } t_out_beat;

    typedef struct packed {
        logic [6:0] cw_m;
        logic [6:0] cw_u;
        logic [6:0] cw_o;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QB-1:0]    quo;
        logic [IDX_W-1:0] idx;
        logic             ovf;
        logic             dz;
        t_side            side;
    } t_dstage;

    typedef logic [255:0][15:0] t_wtab;
    typedef logic [255:0][6:0]  t_ctab;
    typedef logic [255:0][QB:0] t_ttab;

    // log2 in Q30 by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        int k;
        k = 0;
        while (k < 40 && (v >> (k + 1)) != 64'd0) k++;
        m = (v << 30) >> k;
        r = 64'(k) << 30;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (ONE_Q30 << 1)) begin
                m = m >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    // 2^f for f in [0,1), series of exp(f*ln2)
    function automatic logic [63:0] exp2_frac(input logic [63:0] f);
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        z = ((f & FRAC_MASK) * LN2_Q30) >> 30;
        sum = ONE_Q30;
        term = ONE_Q30;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] weight_q16(input logic [63:0] p, input logic [63:0] sg);
        logic [63:0] diff;
        logic [63:0] t;
        logic [63:0] ip;
        logic [63:0] fr;
        logic [63:0] v;
        logic [63:0] w;
        diff = (p >= 64'd128) ? p - 64'd128 : 64'd128 - p;
        t = sg * diff * diff * LOG2E_Q30 / 64'd65025;
        ip = t >> 30;
        fr = t & FRAC_MASK;
        if (fr == 64'd0) v = ONE_Q30 >> ip;
        else v = exp2_frac(ONE_Q30 - fr) >> (ip + 64'd1);
        w = (v + (64'd1 << 13)) >> 14;
        return (w > 64'd65535) ? 64'd65535 : w;
    endfunction

    function automatic logic [63:0] expand_q16(input logic [63:0] p);
        logic [63:0] y;
        if (p == 64'd0) return 64'd0;
        y = log2_q30(p) * 64'd77 / 64'd100;
        return (exp2_frac(y & FRAC_MASK) << (y >> 30)) >> 14;
    endfunction

    function automatic logic [63:0] power_out(input logic [63:0] q);
        logic [63:0] lq;
        logic [63:0] y;
        logic [63:0] ip;
        logic [63:0] r;
        if (q == 64'd0) return 64'd0;
        lq = log2_q30(q);
        if (lq < (64'(QFB) << 30)) return 64'd0;
        y = (lq - (64'(QFB) << 30)) * 64'd13 / 64'd10;
        ip = y >> 30;
        if (ip >= 64'd8) return 64'd255;
        r = (exp2_frac(y & FRAC_MASK) << ip) >> 30;
        return (r > 64'd255) ? 64'd255 : r;
    endfunction

    function automatic t_wtab build_w(input logic [63:0] sg);
        t_wtab tb;
        for (int p = 0; p < 256; p++) tb[p] = 16'(weight_q16(64'(p), sg));
        return tb;
    endfunction

    function automatic t_ctab build_c(input logic [63:0] sg);
        t_ctab tb;
        for (int p = 0; p < 256; p++)
            tb[p] = 7'((expand_q16(64'(p)) * weight_q16(64'(p), sg)) >> 32);
        return tb;
    endfunction

    // Smallest quotient that reaches each output level; unreachable levels sit above range
    function automatic t_ttab build_t();
        t_ttab tb;
        logic [63:0] pw;
        int kk;
        for (int k = 0; k < 256; k++) tb[k] = (QB + 1)'(1 << QB);
        tb[0] = '0;
        kk = 1;
        for (int q = 0; q < (1 << QB); q++) begin
            pw = power_out(64'(q));
            while (kk <= 255 && 64'(kk) <= pw) begin
                tb[kk] = (QB + 1)'(q);
                kk++;
            end
        end
        return tb;
    endfunction

    localparam t_wtab W_COLOR = build_w(64'd8);
    localparam t_wtab W_GRAY  = build_w(64'd5);
    localparam t_ctab C_COLOR = build_c(64'd8);
    localparam t_ctab C_GRAY  = build_c(64'd5);
    localparam t_ttab T_POW   = build_t();

endpackage

@@ hdl/hdr_exposure_merge_3.sv @@
// Channel   Direction  Handshake          Beat
// input     in         i_valid / o_stall  hem3_pkg::t_in_beat (three samples)
// output    out        o_valid / i_stall  hem3_pkg::t_out_beat (merged + weighted)
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One beat enters every cycle while o_stall is low; the registers are table lookup, gain
// multiply-add, divider entry, NSTG divide/search stages and output register.
// NSTG = ceil((QB + 8) / 2), set by the restoring divider and the 8-step level search.
// Reset (synchronous, i_rst_n low) clears valid bits and loads register defaults.
// A stall on the output freezes every stage at once; nothing is lost or repeated.
module hdr_exposure_merge_3 (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hem3_pkg::t_in_beat   i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output hem3_pkg::t_out_beat  o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    logic       r_gray;
    logic [7:0] r_gain_m;
    logic [7:0] r_gain_u;
    logic [7:0] r_gain_o;

    logic        w_en;
    logic        r_v1;
    logic [15:0] r_w_m;
    logic [15:0] r_w_u;
    logic [15:0] r_w_o;
    hem3_pkg::t_side r_side1;

    logic                        r_v2;
    logic [hem3_pkg::NUM_W-1:0]  r_num;
    logic [hem3_pkg::DEN_W-1:0]  r_den;
    hem3_pkg::t_side             r_side2;

    logic            w_dv;
    logic [7:0]      w_merged;
    hem3_pkg::t_side w_dside;

    logic            r_ov;
    hem3_pkg::t_out_beat r_out;

    // Move the whole pipe unless a held result is blocked
    assign w_en    = !(r_ov && i_stall);
    assign o_stall = r_ov && i_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray   <= 1'b0;
            r_gain_m <= 8'd4;
            r_gain_u <= 8'd1;
            r_gain_o <= 8'd16;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                hem3_pkg::REG_GRAY:   r_gray   <= i_cfg_data[0];
                hem3_pkg::REG_GAIN_M: r_gain_m <= i_cfg_data;
                hem3_pkg::REG_GAIN_U: r_gain_u <= i_cfg_data;
                hem3_pkg::REG_GAIN_O: r_gain_o <= i_cfg_data;
            endcase
        end
    end

    // Stage 1: weight and weighted-value lookup
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= i_valid;
        if (w_en) begin
            if (r_gray) begin
                r_w_m <= hem3_pkg::W_GRAY[i_data.median_pixel];
                r_w_u <= hem3_pkg::W_GRAY[i_data.under_pixel];
                r_w_o <= hem3_pkg::W_GRAY[i_data.over_pixel];
                r_side1.cw_m <= hem3_pkg::C_GRAY[i_data.median_pixel];
                r_side1.cw_u <= hem3_pkg::C_GRAY[i_data.under_pixel];
                r_side1.cw_o <= hem3_pkg::C_GRAY[i_data.over_pixel];
            end else begin
                r_w_m <= hem3_pkg::W_COLOR[i_data.median_pixel];
                r_w_u <= hem3_pkg::W_COLOR[i_data.under_pixel];
                r_w_o <= hem3_pkg::W_COLOR[i_data.over_pixel];
                r_side1.cw_m <= hem3_pkg::C_COLOR[i_data.median_pixel];
                r_side1.cw_u <= hem3_pkg::C_COLOR[i_data.under_pixel];
                r_side1.cw_o <= hem3_pkg::C_COLOR[i_data.over_pixel];
            end
        end
    end

    // Stage 2: gain-weighted sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
        if (w_en) begin
            r_num <= hem3_pkg::NUM_W'(r_gain_m) * hem3_pkg::NUM_W'(r_side1.cw_m)
                   + hem3_pkg::NUM_W'(r_gain_u) * hem3_pkg::NUM_W'(r_side1.cw_u)
                   + hem3_pkg::NUM_W'(r_gain_o) * hem3_pkg::NUM_W'(r_side1.cw_o);
            r_den <= hem3_pkg::DEN_W'(r_gain_m) * hem3_pkg::DEN_W'(r_w_m)
                   + hem3_pkg::DEN_W'(r_gain_u) * hem3_pkg::DEN_W'(r_w_u)
                   + hem3_pkg::DEN_W'(r_gain_o) * hem3_pkg::DEN_W'(r_w_o);
            r_side2 <= r_side1;
        end
    end

    hem3_divpow u_divpow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_v2),
        .i_num    (r_num),
        .i_den    (r_den),
        .i_side   (r_side2),
        .o_valid  (w_dv),
        .o_merged (w_merged),
        .o_side   (w_dside)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_en) r_ov <= w_dv;
        if (w_en) begin
            r_out.merged_pixel    <= w_merged;
            r_out.weighted_median <= w_dside.cw_m;
            r_out.weighted_under  <= w_dside.cw_u;
            r_out.weighted_over   <= w_dside.cw_o;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

@@ hdl/hem3_divpow.sv @@
module hem3_divpow (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [hem3_pkg::NUM_W-1:0]   i_num,
    input  logic [hem3_pkg::DEN_W-1:0]   i_den,
    input  hem3_pkg::t_side              i_side,
    output logic                         o_valid,
    output logic [7:0]                   o_merged,
    output hem3_pkg::t_side              o_side
);

    hem3_pkg::t_dstage r_st [hem3_pkg::NSTG+1];
    logic              r_v  [hem3_pkg::NSTG+1];
    hem3_pkg::t_dstage n_st [hem3_pkg::NSTG+1];
    logic [hem3_pkg::DEN_W-1:0] w_shnum;

    // Entry: scale the numerator, flag saturation and empty denominator
    assign w_shnum = {i_num, hem3_pkg::NUM_SH'(0)};

    always_comb begin
        n_st[0].rem  = {1'b0, w_shnum};
        n_st[0].den  = i_den;
        n_st[0].quo  = '0;
        n_st[0].idx  = '0;
        n_st[0].ovf  = (w_shnum >= i_den);
        n_st[0].dz   = (i_den == '0);
        n_st[0].side = i_side;
    end

    // Each stage: two steps, each a restoring divide step while the step index is below QB, else a level search step
    for (genvar g = 0; g < hem3_pkg::NSTG; g++) begin : g_stage
        always_comb begin
            hem3_pkg::t_dstage st;
            logic [hem3_pkg::REM_W-1:0] r2;
            logic [hem3_pkg::IDX_W-1:0] cand;
            int s;
            st = r_st[g];
            for (int j = 0; j < hem3_pkg::STEPS; j++) begin
                s = g * hem3_pkg::STEPS + j;
                r2 = {st.rem[hem3_pkg::REM_W-2:0], 1'b0};
                cand = st.idx | (hem3_pkg::IDX_W'(1) << (hem3_pkg::MSTEPS - 1 - s));
                if (s < hem3_pkg::QB) begin
                    if (r2 >= {1'b0, st.den}) begin
                        st.rem = r2 - {1'b0, st.den};
                        st.quo = {st.quo[hem3_pkg::QB-2:0], 1'b1};
                    end else begin
                        st.rem = r2;
                        st.quo = {st.quo[hem3_pkg::QB-2:0], 1'b0};
                    end
                end else if (s < hem3_pkg::MSTEPS) begin
                    if ({1'b0, st.quo} >= hem3_pkg::T_POW[cand]) st.idx = cand;
                end
            end
            n_st[g+1] = st;
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        for (int g = 0; g <= hem3_pkg::NSTG; g++) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= (g == 0) ? i_valid : r_v[(g == 0) ? 0 : g - 1];
            end
            if (i_en) begin
                r_st[g] <= (g == 0) ? n_st[0] : n_st[g];
            end
        end
    end

    assign o_valid  = r_v[hem3_pkg::NSTG];
    assign o_side   = r_st[hem3_pkg::NSTG].side;
    assign o_merged = r_st[hem3_pkg::NSTG].dz  ? 8'd0 :
                      r_st[hem3_pkg::NSTG].ovf ? 8'd255 : r_st[hem3_pkg::NSTG].idx;

endmodule
